/* rtl/mf8_pkg.sv */
// ----------------------------------------------------------------------------
// mf8_pkg
// shared constants and decode helpers for the 8-bit minifloat add/multiply
// ----------------------------------------------------------------------------
package mf8_pkg;

   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_MUL = 1'b1;

   localparam logic [7:0] SAT_CODE = 8'h5E;

   // magnitude in units of 2^-6: (32 + m) << e, zero for code 0
   function automatic logic [8:0] mag_of(input logic [7:0] code);
      logic [8:0] base;
      base = {3'b0, 1'b1, code[4:0]};
      if (code == 8'h00) begin
         mag_of = 9'd0;
      end else begin
         mag_of = base << code[6:5];
      end
   endfunction

   function automatic logic neg_of(input logic [7:0] code);
      neg_of = (code != 8'h00) && code[7];
   endfunction

endpackage

/* rtl/minifloat8_add_multiply.sv */
// ----------------------------------------------------------------------------
// minifloat8_add_multiply
// add or multiply of two sign/e2/m5 bias-1 minifloat codes
// start passes through the input register and the result register to rsp_valid
// throughput: one operation per cycle, busy is never raised
// results cannot be stalled; each shows for one cycle on rsp_valid
// reset clears the valid pipeline only
// ----------------------------------------------------------------------------
module minifloat8_add_multiply import mf8_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_kind,
   input  logic [7:0] req_operand_a,
   input  logic [7:0] req_operand_b,
   output logic       rsp_valid,
   output logic [7:0] rsp_result
);

   logic       vld_ff, vld_in;
   logic       kind_ff;
   logic [7:0] a_ff, b_ff;
   logic       out_vld_ff;
   logic [7:0] res_ff, res_in;

   logic [8:0]  ma, mb;
   logic        na, nb;
   logic [17:0] prod;
   logic [10:0] sa, sb, sum;
   logic [9:0]  sum_mag;
   logic        neg;
   logic [17:0] mag;

   assign busy   = 1'b0;
   assign vld_in = start;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      kind_ff <= req_kind;
      a_ff    <= req_operand_a;
      b_ff    <= req_operand_b;
   end

   // exact sum or product
   always_comb begin
      ma   = mag_of(a_ff);
      mb   = mag_of(b_ff);
      na   = neg_of(a_ff);
      nb   = neg_of(b_ff);
      prod = ma * mb;
      sa   = na ? -{2'b0, ma} : {2'b0, ma};
      sb   = nb ? -{2'b0, mb} : {2'b0, mb};
      sum  = sa + sb;
      sum_mag = sum[10] ? 10'(-sum) : sum[9:0];
      if (kind_ff == KIND_MUL) begin
         neg = na ^ nb;
         mag = prod;
      end else begin
         neg = sum[10];
         mag = {2'b0, sum_mag, 6'd0};
      end
   end

   mf8_encode u_enc (
      .neg  (neg),
      .mag  (mag),
      .code (res_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff;
      end
      res_ff <= res_in;
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_result = res_ff;

endmodule

/* rtl/mf8_encode.sv */
// ----------------------------------------------------------------------------
// mf8_encode
// re-encodes an exact magnitude (units of 2^-12) with truncation and clamp
// ----------------------------------------------------------------------------
module mf8_encode import mf8_pkg::*; (
   input  logic        neg,
   input  logic [17:0] mag,
   output logic [7:0]  code
);

   logic [4:0] mant;

   // flush to zero or clamp, else pick exponent band and truncate mantissa
   always_comb begin
      mant = 5'd0;
      code = 8'h00;
      priority if (mag < 18'd2048) begin
         code = 8'h00;
      end else if (mag >= 18'd15872) begin
         code = {neg, SAT_CODE[6:0]};
      end else if (mag < 18'd4096) begin
         mant = mag[10:6];
         code = {neg, 2'd0, mant};
      end else if (mag < 18'd8192) begin
         mant = mag[11:7];
         code = {neg, 2'd1, mant};
      end else begin
         mant = mag[12:8];
         code = {neg, 2'd2, mant};
      end
   end

endmodule
